[hw/rtl/modexp_pkg.sv]
// Shared constants and controller/datapath interface types for modular exponentiation.
`timescale 1ns / 1ps

package modexp_pkg;

  // Field widths fixed by the item format
  localparam int unsigned DATA_WIDTH      = 64;
  localparam int unsigned CFG_INDEX_WIDTH = 8;

  // Default operand width used by the arithmetic
  localparam int unsigned OPERAND_WIDTH_DEFAULT = 64;

  // Configuration register indexes
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_EXPONENT = CFG_INDEX_WIDTH'(0);
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_MODULUS  = CFG_INDEX_WIDTH'(1);

  // Commands from the controller to the datapath
  typedef struct packed {
    logic start;        // capture message, load exponent, set result to one
    logic red_step;     // one bit of the message reduction
    logic base_load;    // base takes the product register
    logic mul_setup;    // clear product, pick multiplicand, load multiplier
    logic mul_sel_acc;  // multiplicand is the running result, else the base
    logic mul_step;     // one bit of the modular multiply
    logic acc_load;     // running result takes the product register
    logic e_shift;      // drop the lowest exponent bit
    logic out_load;     // move the running result into the output register
  } modexp_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic e_zero;    // remaining exponent is zero
    logic e_lsb;     // lowest remaining exponent bit
    logic cnt_last;  // bit counter is on the final bit
    logic out_busy;  // output register holds an item that is not taken this cycle
  } modexp_sts_t;

endpackage

[hw/rtl/modular_exponentiation_64.sv]
// Top level of the 64-bit modular exponentiation block.
`timescale 1ns / 1ps

// Computes power_result = message^exponent mod modulus on OPERAND_WIDTH-bit
// unsigned operands, one item at a time. Write exponent (index 0) and modulus
// (index 1) through the config port while the block is idle; a zero modulus
// write is ignored, both registers reset to 1. Each item first reduces the
// message by the modulus, one quotient bit per cycle, then scans the exponent
// from its lowest bit: every bit costs a squaring, and a set bit adds a
// multiply. All modular multiplies share one bit-serial double-and-add unit.
// A new item is accepted while the previous result still waits in the output
// register.
module modular_exponentiation_64 #(
  parameter int unsigned OPERAND_WIDTH = modexp_pkg::OPERAND_WIDTH_DEFAULT
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [modexp_pkg::CFG_INDEX_WIDTH-1:0] cfg_index_i,
  input  logic [modexp_pkg::DATA_WIDTH-1:0]      cfg_data_i,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic [modexp_pkg::DATA_WIDTH-1:0]      message_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic [modexp_pkg::DATA_WIDTH-1:0]      power_result_o
);
  import modexp_pkg::*;

  modexp_cmd_t cmd;
  modexp_sts_t sts;

  // Config writes complete at once
  assign cfg_ready_o = 1'b1;

  modexp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  modexp_dp #(
    .OPERAND_WIDTH (OPERAND_WIDTH)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .message_i      (message_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .power_result_o (power_result_o)
  );

endmodule

[hw/rtl/modexp_ctrl.sv]
// Sequencer for message reduction and right-to-left square-and-multiply.
`timescale 1ns / 1ps

module modexp_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  modexp_pkg::modexp_sts_t sts_i,
  output modexp_pkg::modexp_cmd_t cmd_o
);
  import modexp_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_RED_END,
    ST_CHECK,
    ST_MUL_ACC,
    ST_ACC_END,
    ST_MUL_SQR,
    ST_SQR_END
  } state_e;

  state_e state_q, state_d;
  logic   finish_q, finish_d;

  // Decode commands and next state
  always_comb begin
    state_d  = state_q;
    finish_d = finish_q;
    cmd_o    = '0;
    case (state_q)
      ST_IDLE: begin
        if (finish_q) begin
          // hold the finished result until the output register is free
          if (!sts_i.out_busy) begin
            cmd_o.out_load = 1'b1;
            finish_d       = 1'b0;
          end
        end else if (in_valid_i) begin
          cmd_o.start = 1'b1;
          state_d     = ST_REDUCE;
        end
      end
      ST_REDUCE: begin
        cmd_o.red_step = 1'b1;
        if (sts_i.cnt_last) begin
          state_d = ST_RED_END;
        end
      end
      ST_RED_END: begin
        cmd_o.base_load = 1'b1;
        state_d         = ST_CHECK;
      end
      ST_CHECK: begin
        if (sts_i.e_zero) begin
          finish_d = 1'b1;
          state_d  = ST_IDLE;
        end else if (sts_i.e_lsb) begin
          cmd_o.mul_setup   = 1'b1;
          cmd_o.mul_sel_acc = 1'b1;
          state_d           = ST_MUL_ACC;
        end else begin
          cmd_o.mul_setup = 1'b1;
          state_d         = ST_MUL_SQR;
        end
      end
      ST_MUL_ACC: begin
        cmd_o.mul_step = 1'b1;
        if (sts_i.cnt_last) begin
          state_d = ST_ACC_END;
        end
      end
      ST_ACC_END: begin
        cmd_o.acc_load  = 1'b1;
        cmd_o.mul_setup = 1'b1;
        state_d         = ST_MUL_SQR;
      end
      ST_MUL_SQR: begin
        cmd_o.mul_step = 1'b1;
        if (sts_i.cnt_last) begin
          state_d = ST_SQR_END;
        end
      end
      ST_SQR_END: begin
        cmd_o.base_load = 1'b1;
        cmd_o.e_shift   = 1'b1;
        state_d         = ST_CHECK;
      end
      default: begin
        state_d  = ST_IDLE;
        finish_d = 1'b0;
      end
    endcase
  end

  assign in_ready_o = (state_q == ST_IDLE) && !finish_q;

  // Hold state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      finish_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      finish_q <= finish_d;
    end
  end

endmodule

[hw/rtl/modexp_dp.sv]
// Datapath: key registers, shared bit-serial modular multiplier/reducer, output register.
`timescale 1ns / 1ps

module modexp_dp #(
  parameter int unsigned OPERAND_WIDTH = modexp_pkg::OPERAND_WIDTH_DEFAULT
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_valid_i,
  input  logic [modexp_pkg::CFG_INDEX_WIDTH-1:0] cfg_index_i,
  input  logic [modexp_pkg::DATA_WIDTH-1:0]      cfg_data_i,
  input  logic [modexp_pkg::DATA_WIDTH-1:0]      message_i,
  input  modexp_pkg::modexp_cmd_t                cmd_i,
  output modexp_pkg::modexp_sts_t                sts_o,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic [modexp_pkg::DATA_WIDTH-1:0]      power_result_o
);
  import modexp_pkg::*;

  localparam int unsigned W  = OPERAND_WIDTH;
  localparam int unsigned CW = $clog2(W);

  logic [W-1:0]  exponent_q, modulus_q;
  logic [W-1:0]  e_q, acc_q, base_q, a_q, x_q, p_q;
  logic [W-1:0]  p_d;
  logic [CW-1:0] cnt_q;
  logic [W-1:0]  result_q;
  logic          out_valid_q;

  logic [W-1:0]  cfg_val;
  logic [W:0]    red_rem, dbl, dbl_red_w, sum;
  logic [W-1:0]  dbl_red, addend, acc_red;

  // Key registers; the user must write them only while idle, the block does not enforce it
  assign cfg_val = cfg_data_i[W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exponent_q <= W'(1);
      modulus_q  <= W'(1);
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CFG_EXPONENT) begin
        exponent_q <= cfg_val;
      end else if (cfg_index_i == CFG_MODULUS && cfg_val != '0) begin
        modulus_q <= cfg_val;
      end
    end
  end

  // Reduction step: shift in one message bit, subtract modulus when it fits
  assign red_rem = {p_q, x_q[W-1]};

  // Multiply step: double mod m, then add multiplicand mod m when the bit is set
  assign dbl       = {p_q, 1'b0};
  assign dbl_red_w = (dbl >= {1'b0, modulus_q}) ? dbl - {1'b0, modulus_q} : dbl;
  assign dbl_red   = dbl_red_w[W-1:0];
  assign addend    = x_q[W-1] ? a_q : '0;
  assign sum       = {1'b0, dbl_red} + {1'b0, addend};

  // Running result may be one with a modulus of one
  assign acc_red = (acc_q >= modulus_q) ? acc_q - modulus_q : acc_q;

  always_comb begin
    p_d = p_q;
    if (cmd_i.start || cmd_i.mul_setup) begin
      p_d = '0;
    end else if (cmd_i.red_step) begin
      p_d = (red_rem >= {1'b0, modulus_q}) ? W'(red_rem - {1'b0, modulus_q})
                                           : red_rem[W-1:0];
    end else if (cmd_i.mul_step) begin
      p_d = (sum >= {1'b0, modulus_q}) ? W'(sum - {1'b0, modulus_q}) : sum[W-1:0];
    end
  end

  // Operand and product registers
  always_ff @(posedge clk_i) begin
    p_q <= p_d;
    if (cmd_i.start) begin
      x_q   <= message_i[W-1:0];
      e_q   <= exponent_q;
      acc_q <= W'(1);
    end
    if (cmd_i.mul_setup) begin
      x_q <= base_q;
      a_q <= cmd_i.mul_sel_acc ? acc_red : base_q;
    end
    if (cmd_i.red_step || cmd_i.mul_step) begin
      x_q <= {x_q[W-2:0], 1'b0};
    end
    if (cmd_i.base_load) begin
      base_q <= p_q;
    end
    if (cmd_i.acc_load) begin
      acc_q <= p_q;
    end
    if (cmd_i.e_shift) begin
      e_q <= {1'b0, e_q[W-1:1]};
    end
  end

  // Bit counter for reduction and multiply passes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.start || cmd_i.mul_setup) begin
      cnt_q <= '0;
    end else if (cmd_i.red_step || cmd_i.mul_step) begin
      cnt_q <= cnt_q + CW'(1);
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      result_q <= acc_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign power_result_o = DATA_WIDTH'(result_q);

  assign sts_o.e_zero   = (e_q == '0);
  assign sts_o.e_lsb    = e_q[0];
  assign sts_o.cnt_last = (cnt_q == CW'(W - 1));
  assign sts_o.out_busy = out_valid_q && !out_ready_i;

`ifndef NO_ASSERTIONS
  a_mod_zero_ignored: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i && cfg_index_i == CFG_MODULUS && cfg_val == '0 |=> $stable(modulus_q))
    else $error("zero modulus write changed the modulus");

  a_mul_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.mul_step |=> p_q < modulus_q)
    else $error("product register left the residue range");

  a_acc_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.acc_load |=> acc_q < modulus_q)
    else $error("running result not reduced after multiply");

  a_start_loads_exp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.start |=> e_q == exponent_q && acc_q == W'(1))
    else $error("item start did not load exponent and result");
`endif

endmodule
